// File: sv/gsc_pkg.sv
// Shared constants and types of the gauge sensor conditioner.
`default_nettype none

package gsc_pkg;

   localparam int CHANNELS = 4;

   localparam logic [1:0] CH_FUEL    = 2'd0;
   localparam logic [1:0] CH_COOLANT = 2'd1;
   localparam logic [1:0] CH_BATTERY = 2'd2;
   localparam logic [1:0] CH_OIL     = 2'd3;

   localparam int LIMIT_W = 8;
   localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RESET = 8'd10;
   localparam logic [LIMIT_W-1:0] COUNT_MAX         = 8'd255;

   localparam int SPAN_W  = 8;
   localparam int QUOT_W  = SPAN_W + 1;
   localparam logic [SPAN_W-1:0] FUEL_SPAN    = 8'd100;
   localparam logic [SPAN_W-1:0] COOLANT_SPAN = 8'd170;
   localparam logic [SPAN_W-1:0] BATTERY_SPAN = 8'd16;
   localparam logic [SPAN_W-1:0] OIL_SPAN     = 8'd100;

   localparam int FUEL_W    = 7;
   localparam int COOLANT_W = 9;
   localparam int BATTERY_W = 5;
   localparam int OIL_W     = 7;
   localparam logic [COOLANT_W-1:0] COOLANT_OFFSET = 9'd40;

   typedef logic [CHANNELS-1:0] fault_type;

endpackage : gsc_pkg

`default_nettype wire

// File: sv/gsc_if.sv
// Request, response and register-write channel interfaces of the gauge sensor conditioner.
`default_nettype none

interface gsc_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] fuel_sample;
   logic [SAMPLE_BITS-1:0] coolant_sample;
   logic [SAMPLE_BITS-1:0] battery_sample;
   logic [SAMPLE_BITS-1:0] oil_sample;

   modport source (
      output valid, fuel_sample, coolant_sample, battery_sample, oil_sample,
      input  ready
   );
   modport sink (
      input  valid, fuel_sample, coolant_sample, battery_sample, oil_sample,
      output ready
   );
endinterface : gsc_req_if

interface gsc_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [gsc_pkg::FUEL_W-1:0]      fuel_percent;
   logic signed [gsc_pkg::COOLANT_W-1:0]   coolant_celsius;
   logic        [gsc_pkg::BATTERY_W-1:0]   battery_volts;
   logic        [gsc_pkg::OIL_W-1:0]       oil_bar_tenths;
   logic                                   check_engine;
   logic                                   fuel_fault;
   logic                                   coolant_fault;
   logic                                   battery_fault;
   logic                                   oil_fault;

   modport source (
      output valid, fuel_percent, coolant_celsius, battery_volts, oil_bar_tenths,
             check_engine, fuel_fault, coolant_fault, battery_fault, oil_fault,
      input  ready
   );
   modport sink (
      input  valid, fuel_percent, coolant_celsius, battery_volts, oil_bar_tenths,
             check_engine, fuel_fault, coolant_fault, battery_fault, oil_fault,
      output ready
   );
endinterface : gsc_rsp_if

interface gsc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [gsc_pkg::LIMIT_W-1:0]  data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface : gsc_csr_if

`default_nettype wire

// File: sv/gsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gsc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : gsc_ram

`default_nettype wire

// File: sv/gsc_fault_monitor.sv
// Stuck-sensor fault counters and the fault limit register.
`default_nettype none

module gsc_fault_monitor #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   gsc_csr_if.sink                                            csr_ch,
   input  wire logic                                          sample_accept,
   input  wire logic [gsc_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples,
   output      gsc_pkg::fault_type                            faults
);

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

   logic [gsc_pkg::LIMIT_W-1:0] limit_ff;
   logic [gsc_pkg::LIMIT_W-1:0] limit_in;
   logic [gsc_pkg::LIMIT_W-1:0] count_ff [gsc_pkg::CHANNELS];
   logic [gsc_pkg::LIMIT_W-1:0] count_in [gsc_pkg::CHANNELS];
   gsc_pkg::fault_type          fault_now;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_ch.valid) begin
         limit_in = csr_ch.data;
      end
   end

   always_comb begin
      logic [gsc_pkg::LIMIT_W:0]   inc;
      logic [gsc_pkg::LIMIT_W-1:0] sat;
      logic                        stuck;
      for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
         stuck = (samples[ch] == '0) || (samples[ch] == FULL_SCALE);
         inc   = {1'b0, count_ff[ch]} + (gsc_pkg::LIMIT_W + 1)'(1);
         sat   = inc[gsc_pkg::LIMIT_W] ? gsc_pkg::COUNT_MAX : inc[gsc_pkg::LIMIT_W-1:0];
         fault_now[ch] = 1'b0;
         count_in[ch]  = count_ff[ch];
         if (sample_accept) begin
            count_in[ch] = '0;
         end
         if (stuck) begin
            if (sat >= limit_ff) begin
               fault_now[ch] = 1'b1;
               if (sample_accept) begin
                  count_in[ch] = limit_ff;
               end
            end else if (sample_accept) begin
               count_in[ch] = sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= gsc_pkg::FAULT_LIMIT_RESET;
         for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
            count_ff[ch] <= '0;
         end
      end else begin
         limit_ff <= limit_in;
         for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
            count_ff[ch] <= count_in[ch];
         end
      end
   end

   assign faults = fault_now;

endmodule : gsc_fault_monitor

`default_nettype wire

// File: sv/gsc_scaler.sv
// Mean, gauge scaling pipeline, held gauge values and the response register.
`default_nettype none

module gsc_scaler #(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_BITS   = 10
) (
   input  wire logic                                                  clock,
   input  wire logic                                                  reset,
   input  wire logic                                                  in_valid,
   output      logic                                                  in_ready,
   input  wire logic [SAMPLE_BITS+$clog2(HISTORY_DEPTH)-1:0]          fuel_sum,
   input  wire logic [SAMPLE_BITS+$clog2(HISTORY_DEPTH)-1:0]          coolant_sum,
   input  wire logic [SAMPLE_BITS-1:0]                                battery,
   input  wire logic [SAMPLE_BITS-1:0]                                oil,
   input  wire gsc_pkg::fault_type                                    in_faults,
   gsc_rsp_if.source                                                  rsp_ch
);

   localparam int SUM_W      = SAMPLE_BITS + $clog2(HISTORY_DEPTH);
   localparam int MULT_W     = SUM_W + 1;
   localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int PROD_W     = SUM_W + MULT_W;
   localparam int P_W        = SAMPLE_BITS + gsc_pkg::SPAN_W;
   localparam int E_W        = P_W + 1;
   localparam longint unsigned MEAN_MULT_FULL =
      ((longint'(1) << MEAN_SHIFT) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);
   localparam logic [MULT_W-1:0]  MEAN_MULT  = MULT_W'(MEAN_MULT_FULL);
   localparam logic [E_W-1:0]     FULL_SCALE = E_W'((1 << SAMPLE_BITS) - 1);

   // Stage a: registered sums and direct readings.
   logic                   a_valid_ff, a_valid_in;
   logic [SUM_W-1:0]       a_fsum_ff, a_csum_ff;
   logic [SAMPLE_BITS-1:0] a_batt_ff, a_oil_ff;
   gsc_pkg::fault_type     a_fault_ff;
   // Stage b: mean products.
   logic                   b_valid_ff, b_valid_in;
   logic [PROD_W-1:0]      b_fprod_ff, b_cprod_ff;
   logic [SAMPLE_BITS-1:0] b_batt_ff, b_oil_ff;
   gsc_pkg::fault_type     b_fault_ff;
   // Stage c: span products.
   logic                   c_valid_ff, c_valid_in;
   logic [P_W-1:0]         c_p_ff [gsc_pkg::CHANNELS];
   logic [P_W-1:0]         c_p_in [gsc_pkg::CHANNELS];
   gsc_pkg::fault_type     c_fault_ff;
   // Stage d: quotient estimates.
   logic                      d_valid_ff, d_valid_in;
   logic [P_W-1:0]            d_p_ff  [gsc_pkg::CHANNELS];
   logic [gsc_pkg::QUOT_W-1:0] d_q0_ff [gsc_pkg::CHANNELS];
   logic [gsc_pkg::QUOT_W-1:0] d_q0_in [gsc_pkg::CHANNELS];
   gsc_pkg::fault_type        d_fault_ff;
   // Response register.
   logic                            out_valid_ff, out_valid_in;
   logic [gsc_pkg::QUOT_W-1:0]      quot [gsc_pkg::CHANNELS];
   gsc_pkg::fault_type              out_fault_ff;
   logic [gsc_pkg::FUEL_W-1:0]      held_fuel_ff, held_fuel_in;
   logic [gsc_pkg::COOLANT_W-1:0]   held_coolant_ff, held_coolant_in;
   logic [gsc_pkg::BATTERY_W-1:0]   held_battery_ff, held_battery_in;
   logic [gsc_pkg::OIL_W-1:0]       held_oil_ff, held_oil_in;

   logic a_adv, b_adv, c_adv, d_adv, out_adv, a_load;
   logic [SAMPLE_BITS-1:0] fuel_mean, coolant_mean;

   assign out_adv  = out_valid_ff && rsp_ch.ready;
   assign d_adv    = d_valid_ff && (!out_valid_ff || out_adv);
   assign c_adv    = c_valid_ff && (!d_valid_ff || d_adv);
   assign b_adv    = b_valid_ff && (!c_valid_ff || c_adv);
   assign a_adv    = a_valid_ff && (!b_valid_ff || b_adv);
   assign in_ready = !a_valid_ff || a_adv;
   assign a_load   = in_valid && in_ready;

   assign a_valid_in   = a_load | (a_valid_ff & ~a_adv);
   assign b_valid_in   = a_adv  | (b_valid_ff & ~b_adv);
   assign c_valid_in   = b_adv  | (c_valid_ff & ~c_adv);
   assign d_valid_in   = c_adv  | (d_valid_ff & ~d_adv);
   assign out_valid_in = d_adv  | (out_valid_ff & ~out_adv);

   assign fuel_mean    = b_fprod_ff[MEAN_SHIFT +: SAMPLE_BITS];
   assign coolant_mean = b_cprod_ff[MEAN_SHIFT +: SAMPLE_BITS];

   always_comb begin
      c_p_in[gsc_pkg::CH_FUEL]    = P_W'(fuel_mean)    * P_W'(gsc_pkg::FUEL_SPAN);
      c_p_in[gsc_pkg::CH_COOLANT] = P_W'(coolant_mean) * P_W'(gsc_pkg::COOLANT_SPAN);
      c_p_in[gsc_pkg::CH_BATTERY] = P_W'(b_batt_ff)    * P_W'(gsc_pkg::BATTERY_SPAN);
      c_p_in[gsc_pkg::CH_OIL]     = P_W'(b_oil_ff)     * P_W'(gsc_pkg::OIL_SPAN);
   end

   // Division by full scale: estimate from p + p/2^N, at most one below.
   always_comb begin
      logic [E_W-1:0] est;
      for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
         est         = E_W'(c_p_ff[ch]) + E_W'(c_p_ff[ch] >> SAMPLE_BITS);
         d_q0_in[ch] = est[SAMPLE_BITS +: gsc_pkg::QUOT_W];
      end
   end

   always_comb begin
      logic [E_W-1:0] rem;
      for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
         rem = E_W'(d_p_ff[ch]) - (E_W'(d_q0_ff[ch]) << SAMPLE_BITS) + E_W'(d_q0_ff[ch]);
         quot[ch] = (rem >= FULL_SCALE) ? d_q0_ff[ch] + gsc_pkg::QUOT_W'(1) : d_q0_ff[ch];
      end
   end

   always_comb begin
      held_fuel_in    = held_fuel_ff;
      held_coolant_in = held_coolant_ff;
      held_battery_in = held_battery_ff;
      held_oil_in     = held_oil_ff;
      if (d_adv) begin
         if (!d_fault_ff[gsc_pkg::CH_FUEL]) begin
            held_fuel_in = quot[gsc_pkg::CH_FUEL][gsc_pkg::FUEL_W-1:0];
         end
         if (!d_fault_ff[gsc_pkg::CH_COOLANT]) begin
            held_coolant_in = gsc_pkg::COOLANT_W'(quot[gsc_pkg::CH_COOLANT])
                              - gsc_pkg::COOLANT_OFFSET;
         end
         if (!d_fault_ff[gsc_pkg::CH_BATTERY]) begin
            held_battery_in = quot[gsc_pkg::CH_BATTERY][gsc_pkg::BATTERY_W-1:0];
         end
         if (!d_fault_ff[gsc_pkg::CH_OIL]) begin
            held_oil_in = quot[gsc_pkg::CH_OIL][gsc_pkg::OIL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         d_valid_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
         held_fuel_ff    <= '0;
         held_coolant_ff <= '0;
         held_battery_ff <= '0;
         held_oil_ff     <= '0;
      end else begin
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
         c_valid_ff      <= c_valid_in;
         d_valid_ff      <= d_valid_in;
         out_valid_ff    <= out_valid_in;
         held_fuel_ff    <= held_fuel_in;
         held_coolant_ff <= held_coolant_in;
         held_battery_ff <= held_battery_in;
         held_oil_ff     <= held_oil_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_fsum_ff  <= fuel_sum;
         a_csum_ff  <= coolant_sum;
         a_batt_ff  <= battery;
         a_oil_ff   <= oil;
         a_fault_ff <= in_faults;
      end
      if (a_adv) begin
         b_fprod_ff <= PROD_W'(a_fsum_ff) * PROD_W'(MEAN_MULT);
         b_cprod_ff <= PROD_W'(a_csum_ff) * PROD_W'(MEAN_MULT);
         b_batt_ff  <= a_batt_ff;
         b_oil_ff   <= a_oil_ff;
         b_fault_ff <= a_fault_ff;
      end
      if (b_adv) begin
         for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
            c_p_ff[ch] <= c_p_in[ch];
         end
         c_fault_ff <= b_fault_ff;
      end
      if (c_adv) begin
         for (int ch = 0; ch < gsc_pkg::CHANNELS; ch++) begin
            d_p_ff[ch]  <= c_p_ff[ch];
            d_q0_ff[ch] <= d_q0_in[ch];
         end
         d_fault_ff <= c_fault_ff;
      end
      if (d_adv) begin
         out_fault_ff <= d_fault_ff;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.fuel_percent    = held_fuel_ff;
   assign rsp_ch.coolant_celsius = $signed(held_coolant_ff);
   assign rsp_ch.battery_volts   = held_battery_ff;
   assign rsp_ch.oil_bar_tenths  = held_oil_ff;
   assign rsp_ch.check_engine    = |out_fault_ff;
   assign rsp_ch.fuel_fault      = out_fault_ff[gsc_pkg::CH_FUEL];
   assign rsp_ch.coolant_fault   = out_fault_ff[gsc_pkg::CH_COOLANT];
   assign rsp_ch.battery_fault   = out_fault_ff[gsc_pkg::CH_BATTERY];
   assign rsp_ch.oil_fault       = out_fault_ff[gsc_pkg::CH_OIL];

endmodule : gsc_scaler

`default_nettype wire

// File: sv/gauge_sensor_conditioner.sv
// Top level of the gauge sensor conditioner: history ring, running sums and channel handshakes.
//
// Usage: each request on req_ch carries one set of four converter readings (fuel,
// coolant, battery, oil). Each request produces exactly one response on rsp_ch with
// the four gauge values and the per-channel stuck-sensor fault flags, in request order.
// csr_ch writes the fault limit; it is always ready and should be written only while
// no request is in flight.
// A request passes through the s1 register and the scaler stages a, b, c and d to the response register.
// Throughput: one request per cycle while rsp_ch is not stalled. The history ring lives in a RAM
// with a registered read; the slot is read when the request is accepted and written back from s1,
// so back-to-back requests touch different slots and never wait on each other.
// Reset clears the history (through a first-pass flag), the running sums, the fault
// counters and the held gauge values, and sets the fault limit to 10.
// When the receiver stalls, the response is held and the six pipeline stages keep
// filling; requests are taken until every stage holds an item.
`default_nettype none

module gauge_sensor_conditioner #(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_BITS   = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gsc_req_if.sink    req_ch,
   gsc_rsp_if.source  rsp_ch,
   gsc_csr_if.sink    csr_ch
);

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W = SAMPLE_BITS + PTR_W;
   localparam int RAM_W = 2 * SAMPLE_BITS;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(HISTORY_DEPTH - 1);

   logic                   accept;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]       fuel_sum_ff, fuel_sum_in, coolant_sum_ff, coolant_sum_in;
   logic [SUM_W-1:0]       fuel_sum_next, coolant_sum_next;
   logic                   s1_valid_ff, s1_valid_in, s1_adv;
   logic [PTR_W-1:0]       s1_slot_ff;
   logic                   s1_old_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_fuel_ff, s1_coolant_ff, s1_battery_ff, s1_oil_ff;
   gsc_pkg::fault_type     s1_fault_ff;
   gsc_pkg::fault_type     faults;
   logic [RAM_W-1:0]       rd_data;
   logic [SAMPLE_BITS-1:0] old_fuel, old_coolant;
   logic                   sc_ready;
   logic [gsc_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples;

   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_adv       = s1_valid_ff && sc_ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_adv);

   assign samples[gsc_pkg::CH_FUEL]    = req_ch.fuel_sample;
   assign samples[gsc_pkg::CH_COOLANT] = req_ch.coolant_sample;
   assign samples[gsc_pkg::CH_BATTERY] = req_ch.battery_sample;
   assign samples[gsc_pkg::CH_OIL]     = req_ch.oil_sample;

   gsc_fault_monitor #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_fault_monitor (
      .clock         (clock),
      .reset         (reset),
      .csr_ch        (csr_ch),
      .sample_accept (accept),
      .samples       (samples),
      .faults        (faults)
   );

   gsc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_slot_ff),
      .wr_data ({s1_fuel_ff, s1_coolant_ff}),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Slots not yet written since reset read as zero during the first pass.
   assign old_fuel    = s1_old_valid_ff ? rd_data[RAM_W-1:SAMPLE_BITS] : '0;
   assign old_coolant = s1_old_valid_ff ? rd_data[SAMPLE_BITS-1:0]     : '0;

   assign fuel_sum_next    = fuel_sum_ff - SUM_W'(old_fuel) + SUM_W'(s1_fuel_ff);
   assign coolant_sum_next = coolant_sum_ff - SUM_W'(old_coolant) + SUM_W'(s1_coolant_ff);

   always_comb begin
      ptr_in         = ptr_ff;
      wrapped_in     = wrapped_ff;
      fuel_sum_in    = fuel_sum_ff;
      coolant_sum_in = coolant_sum_ff;
      if (accept) begin
         ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + PTR_W'(1);
         if (ptr_ff == LAST_SLOT) begin
            wrapped_in = 1'b1;
         end
      end
      if (s1_adv) begin
         fuel_sum_in    = fuel_sum_next;
         coolant_sum_in = coolant_sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff         <= '0;
         wrapped_ff     <= 1'b0;
         fuel_sum_ff    <= '0;
         coolant_sum_ff <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         ptr_ff         <= ptr_in;
         wrapped_ff     <= wrapped_in;
         fuel_sum_ff    <= fuel_sum_in;
         coolant_sum_ff <= coolant_sum_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_slot_ff      <= ptr_ff;
         s1_old_valid_ff <= wrapped_ff;
         s1_fuel_ff      <= req_ch.fuel_sample;
         s1_coolant_ff   <= req_ch.coolant_sample;
         s1_battery_ff   <= req_ch.battery_sample;
         s1_oil_ff       <= req_ch.oil_sample;
         s1_fault_ff     <= faults;
      end
   end

   gsc_scaler #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_scaler (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_ready    (sc_ready),
      .fuel_sum    (fuel_sum_next),
      .coolant_sum (coolant_sum_next),
      .battery     (s1_battery_ff),
      .oil         (s1_oil_ff),
      .in_faults   (s1_fault_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule : gauge_sensor_conditioner

`default_nettype wire

// File: sv/gsc_checker.sv
// Port-level assertions of the gauge sensor conditioner and their bind to the top level.
`default_nettype none

module gsc_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_ready,
   input wire logic [gsc_pkg::FUEL_W-1:0]            fuel_percent,
   input wire logic signed [gsc_pkg::COOLANT_W-1:0]  coolant_celsius,
   input wire logic [gsc_pkg::BATTERY_W-1:0]         battery_volts,
   input wire logic [gsc_pkg::OIL_W-1:0]             oil_bar_tenths,
   input wire logic                                  check_engine,
   input wire logic                                  fuel_fault,
   input wire logic                                  coolant_fault,
   input wire logic                                  battery_fault,
   input wire logic                                  oil_fault
);

   logic                                 rsp_fire;
   logic [gsc_pkg::FUEL_W-1:0]           last_fuel_ff;
   logic [gsc_pkg::COOLANT_W-1:0]        last_coolant_ff;
   logic [gsc_pkg::BATTERY_W-1:0]        last_battery_ff;
   logic [gsc_pkg::OIL_W-1:0]            last_oil_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fuel_ff    <= '0;
         last_coolant_ff <= '0;
         last_battery_ff <= '0;
         last_oil_ff     <= '0;
      end else if (rsp_fire) begin
         last_fuel_ff    <= fuel_percent;
         last_coolant_ff <= coolant_celsius;
         last_battery_ff <= battery_volts;
         last_oil_ff     <= oil_bar_tenths;
      end
   end

   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   check_engine_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> check_engine == (fuel_fault || coolant_fault || battery_fault || oil_fault))
      else $error("check_engine does not match the channel faults");

   gauge_range_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fuel_percent <= 7'd100 && oil_bar_tenths <= 7'd100
                    && battery_volts <= 5'd16
                    && coolant_celsius >= -9'sd40 && coolant_celsius <= 9'sd130)
      else $error("gauge value out of range");

   held_value_a: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (!fuel_fault || fuel_percent == last_fuel_ff)
                   && (!coolant_fault || coolant_celsius == $signed(last_coolant_ff))
                   && (!battery_fault || battery_volts == last_battery_ff)
                   && (!oil_fault || oil_bar_tenths == last_oil_ff))
      else $error("faulted channel did not hold its last gauge value");

endmodule : gsc_checker

bind gauge_sensor_conditioner gsc_checker u_gsc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .fuel_percent    (rsp_ch.fuel_percent),
   .coolant_celsius (rsp_ch.coolant_celsius),
   .battery_volts   (rsp_ch.battery_volts),
   .oil_bar_tenths  (rsp_ch.oil_bar_tenths),
   .check_engine    (rsp_ch.check_engine),
   .fuel_fault      (rsp_ch.fuel_fault),
   .coolant_fault   (rsp_ch.coolant_fault),
   .battery_fault   (rsp_ch.battery_fault),
   .oil_fault       (rsp_ch.oil_fault)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench of the gauge sensor conditioner with a predicting scoreboard.
`timescale 1ns / 100ps

module testbench;

   localparam int              SAMPLE_W   = 10;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
   localparam int              RING_DEPTH = 8;
   localparam int              SETTLE_CYCLES = 10;

   typedef struct {
      logic        [gsc_pkg::FUEL_W-1:0]    fuel_percent;
      logic signed [gsc_pkg::COOLANT_W-1:0] coolant_celsius;
      logic        [gsc_pkg::BATTERY_W-1:0] battery_volts;
      logic        [gsc_pkg::OIL_W-1:0]     oil_bar_tenths;
      logic                                 check_engine;
      gsc_pkg::fault_type                   faults;
   } gauge_result_type;

   class gauge_tracker_type;
      logic [gsc_pkg::LIMIT_W-1:0] fault_limit;
      logic [SAMPLE_W-1:0]         fuel_ring [RING_DEPTH];
      logic [SAMPLE_W-1:0]         coolant_ring [RING_DEPTH];
      logic [2:0]                  slot;
      logic [12:0]                 fuel_sum;
      logic [12:0]                 coolant_sum;
      logic [gsc_pkg::LIMIT_W-1:0] stuck_count [gsc_pkg::CHANNELS];
      gauge_result_type            held;
      gauge_result_type            awaited_gauges [$];
      int                          mismatches;
      int                          compared;
      int                          faulted_responses;

      function new();
         fault_limit = gsc_pkg::FAULT_LIMIT_RESET;
         foreach (fuel_ring[i]) begin
            fuel_ring[i] = '0;
            coolant_ring[i] = '0;
         end
         foreach (stuck_count[i]) stuck_count[i] = '0;
         slot = '0;
         fuel_sum = '0;
         coolant_sum = '0;
         held.fuel_percent = '0;
         held.coolant_celsius = '0;
         held.battery_volts = '0;
         held.oil_bar_tenths = '0;
         held.check_engine = 1'b0;
         held.faults = '0;
         mismatches = 0;
         compared = 0;
         faulted_responses = 0;
      endfunction

      function void set_limit(logic [gsc_pkg::LIMIT_W-1:0] limit);
         fault_limit = limit;
      endfunction

      function int outstanding();
         return awaited_gauges.size();
      endfunction

      function bit advance_stuck(logic [SAMPLE_W-1:0] sample, int ch);
         int next_count;
         if (sample == '0 || sample == SAMPLE_MAX) begin
            next_count = int'(stuck_count[ch]) + 1;
            if (next_count > int'(gsc_pkg::COUNT_MAX)) next_count = int'(gsc_pkg::COUNT_MAX);
            if (next_count >= int'(fault_limit)) begin
               stuck_count[ch] = fault_limit;
               return 1'b1;
            end
            stuck_count[ch] = gsc_pkg::LIMIT_W'(next_count);
            return 1'b0;
         end
         stuck_count[ch] = '0;
         return 1'b0;
      endfunction

      function void note_request(logic [SAMPLE_W-1:0] fuel, logic [SAMPLE_W-1:0] coolant,
                                 logic [SAMPLE_W-1:0] battery, logic [SAMPLE_W-1:0] oil);
         gsc_pkg::fault_type faults;
         int                 fuel_mean;
         int                 coolant_mean;
         int                 celsius;
         gauge_result_type   gauge;
         faults[gsc_pkg::CH_FUEL]    = advance_stuck(fuel, gsc_pkg::CH_FUEL);
         faults[gsc_pkg::CH_COOLANT] = advance_stuck(coolant, gsc_pkg::CH_COOLANT);
         faults[gsc_pkg::CH_BATTERY] = advance_stuck(battery, gsc_pkg::CH_BATTERY);
         faults[gsc_pkg::CH_OIL]     = advance_stuck(oil, gsc_pkg::CH_OIL);
         fuel_sum = fuel_sum - 13'(fuel_ring[slot]) + 13'(fuel);
         coolant_sum = coolant_sum - 13'(coolant_ring[slot]) + 13'(coolant);
         fuel_ring[slot] = fuel;
         coolant_ring[slot] = coolant;
         slot = slot + 3'd1;
         fuel_mean = int'(fuel_sum) / RING_DEPTH;
         coolant_mean = int'(coolant_sum) / RING_DEPTH;
         if (!faults[gsc_pkg::CH_FUEL])
            held.fuel_percent = gsc_pkg::FUEL_W'(
               fuel_mean * int'(gsc_pkg::FUEL_SPAN) / int'(SAMPLE_MAX));
         if (!faults[gsc_pkg::CH_COOLANT]) begin
            celsius = coolant_mean * int'(gsc_pkg::COOLANT_SPAN) / int'(SAMPLE_MAX)
                      - int'(gsc_pkg::COOLANT_OFFSET);
            held.coolant_celsius = gsc_pkg::COOLANT_W'(celsius);
         end
         if (!faults[gsc_pkg::CH_BATTERY])
            held.battery_volts = gsc_pkg::BATTERY_W'(
               int'(battery) * int'(gsc_pkg::BATTERY_SPAN) / int'(SAMPLE_MAX));
         if (!faults[gsc_pkg::CH_OIL])
            held.oil_bar_tenths = gsc_pkg::OIL_W'(
               int'(oil) * int'(gsc_pkg::OIL_SPAN) / int'(SAMPLE_MAX));
         gauge = held;
         gauge.faults = faults;
         gauge.check_engine = |faults;
         awaited_gauges.push_back(gauge);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report_mismatch($sformatf("response %0d %s = %0d, expected %0d",
                                      compared, name, got, want));
      endtask

      task check_response(gauge_result_type got);
         gauge_result_type want;
         if (awaited_gauges.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
            return;
         end
         want = awaited_gauges.pop_front();
         compare_field("fuel_percent", int'(got.fuel_percent), int'(want.fuel_percent));
         compare_field("coolant_celsius", int'(got.coolant_celsius),
                       int'(want.coolant_celsius));
         compare_field("battery_volts", int'(got.battery_volts), int'(want.battery_volts));
         compare_field("oil_bar_tenths", int'(got.oil_bar_tenths), int'(want.oil_bar_tenths));
         compare_field("check_engine", int'(got.check_engine), int'(want.check_engine));
         compare_field("fuel_fault", int'(got.faults[gsc_pkg::CH_FUEL]),
                       int'(want.faults[gsc_pkg::CH_FUEL]));
         compare_field("coolant_fault", int'(got.faults[gsc_pkg::CH_COOLANT]),
                       int'(want.faults[gsc_pkg::CH_COOLANT]));
         compare_field("battery_fault", int'(got.faults[gsc_pkg::CH_BATTERY]),
                       int'(want.faults[gsc_pkg::CH_BATTERY]));
         compare_field("oil_fault", int'(got.faults[gsc_pkg::CH_OIL]),
                       int'(want.faults[gsc_pkg::CH_OIL]));
         if (want.check_engine) faulted_responses++;
         compared++;
      endtask
   endclass

   logic clock;
   logic reset;

   gsc_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   gsc_rsp_if                           rsp_bus ();
   gsc_csr_if                           csr_bus ();

   gauge_sensor_conditioner #(
      .HISTORY_DEPTH(RING_DEPTH),
      .SAMPLE_BITS  (SAMPLE_W)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   gauge_tracker_type tracker;
   bit                no_idle;
   int                stuck_run [gsc_pkg::CHANNELS];
   int                run_span;
   int                limit_writes;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.fuel_sample = '0;
      req_bus.coolant_sample = '0;
      req_bus.battery_sample = '0;
      req_bus.oil_sample = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
   end

   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rail_sample();
      return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
   endfunction

   function automatic logic [SAMPLE_W-1:0] next_sample(int ch);
      int pick;
      if (stuck_run[ch] > 0) begin
         stuck_run[ch]--;
         return rail_sample();
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         stuck_run[ch] = $urandom_range(0, run_span + 2);
         return rail_sample();
      end
      if (pick < 20) return rail_sample();
      if (pick < 26) return $urandom_range(0, 1) ? SAMPLE_MAX - 10'd1 : 10'd1;
      return SAMPLE_W'($urandom_range(0, int'(SAMPLE_MAX)));
   endfunction

   task automatic send_reading(logic [SAMPLE_W-1:0] fuel, logic [SAMPLE_W-1:0] coolant,
                               logic [SAMPLE_W-1:0] battery, logic [SAMPLE_W-1:0] oil);
      int gap;
      gap = draw_idle();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.fuel_sample = fuel;
      req_bus.coolant_sample = coolant;
      req_bus.battery_sample = battery;
      req_bus.oil_sample = oil;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(fuel, coolant, battery, oil);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fault_limit(logic [gsc_pkg::LIMIT_W-1:0] limit);
      wait_idle();
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.data = limit;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.set_limit(limit);
      limit_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
      run_span = (limit > 20) ? 20 : int'(limit);
   endtask

   task automatic run_random_phase(logic [gsc_pkg::LIMIT_W-1:0] limit, int count, bit pin_oil);
      logic [SAMPLE_W-1:0] oil;
      write_fault_limit(limit);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         oil = pin_oil ? rail_sample() : next_sample(gsc_pkg::CH_OIL);
         send_reading(next_sample(gsc_pkg::CH_FUEL), next_sample(gsc_pkg::CH_COOLANT),
                      next_sample(gsc_pkg::CH_BATTERY), oil);
      end
   endtask

   initial begin
      gauge_result_type got;
      @(negedge reset);
      forever begin
         int stall;
         stall = draw_idle();
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.fuel_percent = rsp_bus.fuel_percent;
         got.coolant_celsius = rsp_bus.coolant_celsius;
         got.battery_volts = rsp_bus.battery_volts;
         got.oil_bar_tenths = rsp_bus.oil_bar_tenths;
         got.check_engine = rsp_bus.check_engine;
         got.faults[gsc_pkg::CH_FUEL] = rsp_bus.fuel_fault;
         got.faults[gsc_pkg::CH_COOLANT] = rsp_bus.coolant_fault;
         got.faults[gsc_pkg::CH_BATTERY] = rsp_bus.battery_fault;
         got.faults[gsc_pkg::CH_OIL] = rsp_bus.oil_fault;
         tracker.check_response(got);
      end
   end

   initial begin
      tracker = new();
      no_idle = 1'b0;
      limit_writes = 0;
      run_span = int'(gsc_pkg::FAULT_LIMIT_RESET);
      foreach (stuck_run[i]) stuck_run[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The reset limit of ten: rails, near-rails, then a stuck run that faults every channel.
      send_reading(10'd512, 10'd512, 10'd512, 10'd512);
      send_reading(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_reading(10'd1, SAMPLE_MAX - 10'd1, 10'd1, SAMPLE_MAX - 10'd1);
      repeat (10) send_reading('0, '0, '0, '0);
      send_reading(SAMPLE_MAX, '0, SAMPLE_MAX, '0);
      send_reading(10'd700, 10'd300, 10'd900, 10'd100);

      // A zero limit faults on the first stuck reading.
      write_fault_limit(8'd0);
      send_reading('0, 10'd600, SAMPLE_MAX, 10'd400);
      send_reading(10'd200, 10'd200, 10'd200, 10'd200);

      // Lowering the limit below a running count clamps it on the next stuck reading.
      write_fault_limit(8'd255);
      repeat (5) send_reading(SAMPLE_MAX, 10'd333, 10'd444, 10'd555);
      write_fault_limit(8'd2);
      send_reading('0, 10'd333, 10'd444, 10'd555);
      send_reading('0, SAMPLE_MAX, '0, SAMPLE_MAX);
      send_reading(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);

      run_random_phase(8'd1, 40, 1'b0);
      run_random_phase(8'd3, 40, 1'b0);
      run_random_phase(gsc_pkg::LIMIT_W'($urandom_range(2, 20)), 40, 1'b0);
      run_random_phase(8'd255, 270, 1'b1);
      run_random_phase(8'd0, 25, 1'b0);
      run_random_phase(gsc_pkg::FAULT_LIMIT_RESET, 40, 1'b0);

      wait_idle();
      $display("Checked %0d responses over %0d fault-limit writes, %0d of them with a fault.",
               tracker.compared, limit_writes, tracker.faulted_responses);
      $display("Limits covered zero, one, a lowered limit and 255 with a channel stuck for 270.");
      if (tracker.mismatches == 0) begin
         $display("[gauge_sensor_conditioner] OK");
      end else begin
         $display("[gauge_sensor_conditioner] ERROR");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timed out with %0d responses outstanding.", tracker.outstanding());
      $display("[gauge_sensor_conditioner] ERROR");
      $finish;
   end

endmodule : testbench
